// ===== sv/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Command codes carried on the input kind field
  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_WRITE    = 3'd3,
    FN_READ     = 3'd4,
    FN_WAIT_ACK = 3'd5,
    FN_RSVD6    = 3'd6,
    FN_RSVD7    = 3'd7
  } func_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_SS_HOLD   = 2'd0;
  localparam logic [1:0] CFG_BIT_HALF  = 2'd1;
  localparam logic [1:0] CFG_ACK_LIMIT = 2'd2;

  localparam logic [7:0] SS_HOLD_RST   = 8'd4;
  localparam logic [7:0] BIT_HALF_RST  = 8'd2;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_SP1  = 4'd3,
    PH_SP2  = 4'd4,
    PH_WL   = 4'd5,
    PH_WH   = 4'd6,
    PH_WT   = 4'd7,
    PH_RL   = 4'd8,
    PH_RH   = 4'd9,
    PH_AL   = 4'd10,
    PH_AH   = 4'd11,
    PH_K1   = 4'd12,
    PH_K2   = 4'd13,
    PH_KP   = 4'd14
  } phase_e;

  typedef struct packed {
    logic [7:0] ss_hold;
    logic [7:0] bit_half;
    logic [7:0] ack_limit;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] hold;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [7:0] poll;
    logic       ack_choice;
    logic       scl;
    logic       sda;
    logic       sda_rel;
    logic       timeout;
    logic [7:0] rx;
  } seq_state_t;

  // Result item, lowest field last
  typedef struct packed {
    logic       rejected;
    logic       ack_timeout;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_released;
    logic       sda_level;
    logic       scl_level;
  } result_t;

  // A zero hold counts as one tick
  function automatic logic [7:0] hold_val(input logic [7:0] v);
    hold_val = (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/i2c_master_bit_sequencer_unit.sv =====
// A result item appears in the output register in the cycle after its input item is accepted.
// Throughput: one item per clock while the output is not stalled; the state update is a single registered step.
// An input item is taken whenever the output register is empty or being drained.
// Reset (rst_ni low, asynchronous): sequencer idle, SCL and SDA driven high,
// registers back to hold 4, half period 2, ack poll limit 250; output empty.
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// I2C master line sequencer: commands, per-tick line stepping and results.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] send_ack, [9] sda_in
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] scl_level, [1] sda_level, [2] sda_released,
                                      // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                      // [13] ack_timeout, [14] rejected
);
  import i2cms_pkg::*;

  cfg_t       cfg_q;
  seq_state_t st_q, st_d;
  result_t    res_q, res_d;
  logic       vld_q;
  logic       in_acc;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ss_hold   <= SS_HOLD_RST;
      cfg_q.bit_half  <= BIT_HALF_RST;
      cfg_q.ack_limit <= ACK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SS_HOLD:   cfg_q.ss_hold   <= cfg_data_i;
        CFG_BIT_HALF:  cfg_q.bit_half  <= cfg_data_i;
        CFG_ACK_LIMIT: cfg_q.ack_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cms_step u_step (
    .st_i       (st_q),
    .cfg_i      (cfg_q),
    .func_i     (s_axis_tuser),
    .tx_byte_i  (s_axis_tdata[7:0]),
    .send_ack_i (s_axis_tdata[8]),
    .sda_in_i   (s_axis_tdata[9]),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_IDLE;
      st_q.hold       <= 8'd0;
      st_q.bit_cnt    <= 4'd0;
      st_q.shift      <= 8'd0;
      st_q.poll       <= 8'd0;
      st_q.ack_choice <= 1'b0;
      st_q.scl        <= 1'b1;
      st_q.sda        <= 1'b1;
      st_q.sda_rel    <= 1'b0;
      st_q.timeout    <= 1'b0;
      st_q.rx         <= 8'd0;
      vld_q           <= 1'b0;
    end else begin
      if (in_acc) begin
        st_q  <= st_d;
        vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {1'b0, res_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q)
    else $error("accepted item produced no result");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (vld_q && !m_axis_tready))
    else $error("input stalled while output free");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res_q.done) |-> !res_q.busy && (st_q.phase == PH_IDLE || $past(vld_q)))
    else $error("done result while still busy");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_d.rejected) |-> (st_q.phase != PH_IDLE) && res_d.busy)
    else $error("command rejected while idle");

endmodule

`default_nettype wire

// ===== sv/i2cms_step.sv =====
// ----------------------------------------------------------------------------
// i2cms_step
// Next-state and result logic for one item of the bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_step (
  input  i2cms_pkg::seq_state_t st_i,
  input  i2cms_pkg::cfg_t       cfg_i,
  input  logic [2:0]            func_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  send_ack_i,
  input  logic                  sda_in_i,
  output i2cms_pkg::seq_state_t st_o,
  output i2cms_pkg::result_t    res_o
);
  import i2cms_pkg::*;

  seq_state_t nst;
  logic       done;
  logic       rej;
  logic [7:0] hold_dec;
  logic [3:0] bit_inc;
  logic [8:0] poll_inc;

  always_comb begin
    nst      = st_i;
    done     = 1'b0;
    rej      = 1'b0;
    hold_dec = (st_i.hold == 8'd0) ? 8'd0 : st_i.hold - 8'd1;
    bit_inc  = st_i.bit_cnt + 4'd1;
    poll_inc = {1'b0, st_i.poll} + 9'd1;

    case (func_e'(func_i))
      FN_START, FN_STOP, FN_WRITE, FN_READ, FN_WAIT_ACK: begin
        if (st_i.phase != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          nst.timeout = 1'b0;
          nst.bit_cnt = 4'd0;
          case (func_e'(func_i))
            FN_START: begin
              nst.scl = 1'b1; nst.sda = 1'b1; nst.sda_rel = 1'b0;
              nst.phase = PH_ST1; nst.hold = hold_val(cfg_i.ss_hold);
            end
            FN_STOP: begin
              nst.scl = 1'b0; nst.sda = 1'b0; nst.sda_rel = 1'b0;
              nst.phase = PH_SP1; nst.hold = hold_val(cfg_i.ss_hold);
            end
            FN_WRITE: begin
              nst.sda_rel = 1'b0; nst.scl = 1'b0;
              nst.sda = tx_byte_i[7];
              nst.shift = {tx_byte_i[6:0], 1'b0};
              nst.phase = PH_WL; nst.hold = hold_val(cfg_i.bit_half);
            end
            FN_READ: begin
              nst.sda_rel = 1'b1; nst.scl = 1'b0; nst.shift = 8'd0;
              nst.ack_choice = send_ack_i;
              nst.phase = PH_RL; nst.hold = hold_val(cfg_i.bit_half);
            end
            default: begin
              nst.sda_rel = 1'b1; nst.sda = 1'b1; nst.poll = 8'd0;
              nst.phase = PH_K1; nst.hold = 8'd1;
            end
          endcase
        end
      end
      FN_TICK: begin
        if (st_i.phase == PH_KP) begin
          if (!sda_in_i) begin
            nst.scl = 1'b0;
            done    = 1'b1;
          end else if (poll_inc > {1'b0, cfg_i.ack_limit}) begin
            // timeout: run the stop sequence, flag stays until next command
            nst.timeout = 1'b1;
            nst.scl = 1'b0; nst.sda = 1'b0; nst.sda_rel = 1'b0;
            nst.phase = PH_SP1; nst.hold = hold_val(cfg_i.ss_hold);
          end else begin
            nst.poll = poll_inc[7:0];
          end
        end else if (st_i.phase != PH_IDLE) begin
          nst.hold = hold_dec;
          if (hold_dec == 8'd0) begin
            case (st_i.phase)
              PH_ST1: begin
                nst.sda = 1'b0; nst.phase = PH_ST2; nst.hold = hold_val(cfg_i.ss_hold);
              end
              PH_ST2: begin
                nst.scl = 1'b0; done = 1'b1;
              end
              PH_SP1: begin
                nst.scl = 1'b1; nst.sda = 1'b1;
                nst.phase = PH_SP2; nst.hold = hold_val(cfg_i.ss_hold);
              end
              PH_SP2: done = 1'b1;
              PH_WL: begin
                nst.scl = 1'b1; nst.phase = PH_WH; nst.hold = hold_val(cfg_i.bit_half);
              end
              PH_WH: begin
                nst.scl = 1'b0; nst.phase = PH_WT; nst.hold = hold_val(cfg_i.bit_half);
              end
              PH_WT: begin
                nst.bit_cnt = bit_inc;
                if (bit_inc >= BITS_PER_BYTE) begin
                  done = 1'b1;
                end else begin
                  nst.sda   = st_i.shift[7];
                  nst.shift = {st_i.shift[6:0], 1'b0};
                  nst.phase = PH_WL; nst.hold = hold_val(cfg_i.bit_half);
                end
              end
              PH_RL: begin
                nst.scl     = 1'b1;
                nst.shift   = {st_i.shift[6:0], sda_in_i};
                nst.bit_cnt = bit_inc;
                nst.phase   = PH_RH; nst.hold = 8'd1;
              end
              PH_RH: begin
                nst.scl = 1'b0;
                if (st_i.bit_cnt >= BITS_PER_BYTE) begin
                  nst.sda_rel = 1'b0;
                  nst.sda     = ~st_i.ack_choice;
                  nst.phase   = PH_AL;
                end else begin
                  nst.phase = PH_RL;
                end
                nst.hold = hold_val(cfg_i.bit_half);
              end
              PH_AL: begin
                nst.scl = 1'b1; nst.phase = PH_AH; nst.hold = hold_val(cfg_i.bit_half);
              end
              PH_AH: begin
                nst.scl = 1'b0; nst.rx = st_i.shift; done = 1'b1;
              end
              PH_K1: begin
                nst.scl = 1'b1; nst.phase = PH_K2; nst.hold = 8'd1;
              end
              PH_K2: begin
                nst.phase = PH_KP; nst.poll = 8'd0;
              end
              default: done = 1'b1;
            endcase
          end
        end
        if (done) begin
          nst.phase = PH_IDLE;
        end
      end
      default: ;  // unused codes change nothing
    endcase
  end

  assign st_o = nst;

  always_comb begin
    res_o.scl_level    = nst.scl;
    res_o.sda_level    = nst.sda;
    res_o.sda_released = nst.sda_rel;
    res_o.busy         = (nst.phase != PH_IDLE);
    res_o.done         = done;
    res_o.rx_byte      = nst.rx;
    res_o.ack_timeout  = nst.timeout;
    res_o.rejected     = rej;
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master bit sequencer. A directed table and
// random command sequences drive the input stream under varied register
// settings and backpressure; each result item is compared field by field
// against a cycle-free model of the line sequencer kept in this module.
// ----------------------------------------------------------------------------
module testbench;
  import i2cms_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [7:0] tx_byte, [8] send_ack, [9] sda_in
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] scl_level, [1] sda_level, [2] sda_released,
                                     // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                     // [13] ack_timeout, [14] rejected

  i2c_master_bit_sequencer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("i2c_master_bit_sequencer_unit regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Line sequencer model
  // --------------------------------------------------------------------------
  cfg_t       seq_cfg;
  phase_e     seq_ph;
  logic [7:0] seq_hold, seq_shift, seq_polls, seq_rx;
  logic [3:0] seq_bits;
  logic       seq_ack_sel, seq_scl, seq_sda, seq_rel, seq_tmo;

  function automatic void load_phase(phase_e p, logic [7:0] n);
    seq_ph   = p;
    seq_hold = (n == 8'd0) ? 8'd1 : n;   // zero hold still lasts one tick
  endfunction

  function automatic void begin_stop();
    seq_scl = 1'b0;
    seq_sda = 1'b0;
    seq_rel = 1'b0;
    load_phase(PH_SP1, seq_cfg.ss_hold);
  endfunction

  function automatic void shift_out();
    seq_sda   = seq_shift[7];
    seq_shift = seq_shift << 1;
  endfunction

  // hold count ran out: move on; returns 1 when the sequence completes
  function automatic logic phase_end(logic sda);
    case (seq_ph)
      PH_ST1: begin
        seq_sda = 1'b0;
        load_phase(PH_ST2, seq_cfg.ss_hold);
      end
      PH_ST2: begin
        seq_scl = 1'b0;
        return 1'b1;
      end
      PH_SP1: begin
        seq_scl = 1'b1;
        seq_sda = 1'b1;
        load_phase(PH_SP2, seq_cfg.ss_hold);
      end
      PH_SP2: return 1'b1;
      PH_WL: begin
        seq_scl = 1'b1;
        load_phase(PH_WH, seq_cfg.bit_half);
      end
      PH_WH: begin
        seq_scl = 1'b0;
        load_phase(PH_WT, seq_cfg.bit_half);
      end
      PH_WT: begin
        seq_bits = seq_bits + 4'd1;
        if (seq_bits >= BITS_PER_BYTE) return 1'b1;
        shift_out();
        load_phase(PH_WL, seq_cfg.bit_half);
      end
      PH_RL: begin
        seq_scl   = 1'b1;
        seq_shift = {seq_shift[6:0], sda};
        seq_bits  = seq_bits + 4'd1;
        load_phase(PH_RH, 8'd1);
      end
      PH_RH: begin
        seq_scl = 1'b0;
        if (seq_bits >= BITS_PER_BYTE) begin
          seq_rel = 1'b0;
          seq_sda = !seq_ack_sel;
          load_phase(PH_AL, seq_cfg.bit_half);
        end else begin
          load_phase(PH_RL, seq_cfg.bit_half);
        end
      end
      PH_AL: begin
        seq_scl = 1'b1;
        load_phase(PH_AH, seq_cfg.bit_half);
      end
      PH_AH: begin
        seq_scl = 1'b0;
        seq_rx  = seq_shift;
        return 1'b1;
      end
      PH_K1: begin
        seq_scl = 1'b1;
        load_phase(PH_K2, 8'd1);
      end
      PH_K2: begin
        seq_ph    = PH_KP;
        seq_polls = 8'd0;
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic result_t sequencer_step(func_e fn, logic [7:0] tx, logic sack,
                                             logic sda);
    logic    fin;
    logic    rej;
    result_t r;
    fin = 1'b0;
    rej = 1'b0;
    if (fn >= FN_START && fn <= FN_WAIT_ACK) begin
      if (seq_ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        seq_tmo  = 1'b0;
        seq_bits = 4'd0;
        case (fn)
          FN_START: begin
            seq_scl = 1'b1;
            seq_sda = 1'b1;
            seq_rel = 1'b0;
            load_phase(PH_ST1, seq_cfg.ss_hold);
          end
          FN_STOP: begin_stop();
          FN_WRITE: begin
            seq_rel   = 1'b0;
            seq_scl   = 1'b0;
            seq_shift = tx;
            shift_out();
            load_phase(PH_WL, seq_cfg.bit_half);
          end
          FN_READ: begin
            seq_rel     = 1'b1;
            seq_scl     = 1'b0;
            seq_shift   = 8'd0;
            seq_ack_sel = sack;
            load_phase(PH_RL, seq_cfg.bit_half);
          end
          default: begin
            // SCL stays where it is until the clock-high step
            seq_rel   = 1'b1;
            seq_sda   = 1'b1;
            seq_polls = 8'd0;
            load_phase(PH_K1, 8'd1);
          end
        endcase
      end
    end else if (fn == FN_TICK && seq_ph != PH_IDLE) begin
      if (seq_ph == PH_KP) begin
        if (!sda) begin
          seq_scl = 1'b0;
          fin     = 1'b1;
        end else if ({1'b0, seq_polls} + 9'd1 > {1'b0, seq_cfg.ack_limit}) begin
          seq_tmo = 1'b1;
          begin_stop();
        end else begin
          seq_polls = seq_polls + 8'd1;
        end
      end else begin
        if (seq_hold != 8'd0) seq_hold = seq_hold - 8'd1;
        if (seq_hold == 8'd0) fin = phase_end(sda);
      end
      if (fin) seq_ph = PH_IDLE;
    end
    r.scl_level    = seq_scl;
    r.sda_level    = seq_sda;
    r.sda_released = seq_rel;
    r.busy         = (seq_ph != PH_IDLE);
    r.done         = fin;
    r.rx_byte      = seq_rx;
    r.ack_timeout  = seq_tmo;
    r.rejected     = rej;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and receiver backpressure
  // --------------------------------------------------------------------------
  result_t expected_lines[$];
  int      n_errs = 0;
  int      n_items = 0;
  int      n_checked = 0;
  int      n_done = 0;
  int      n_tmo = 0;
  int      n_rej = 0;
  int      send_gap_pct = 0;
  int      recv_gap_pct = 0;
  int      holdoff_len = 0;
  int      holdoff_left = 0;

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errs++;
    end
  endfunction

  always @(posedge clk_i) begin : result_side
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[14:0];
        if (expected_lines.size() == 0) begin
          $error("result item with no input item pending: %h", m_axis_tdata);
          n_errs++;
        end else begin
          want = expected_lines.pop_front();
          cmp_field("scl_level", want.scl_level, got.scl_level);
          cmp_field("sda_level", want.sda_level, got.sda_level);
          cmp_field("sda_released", want.sda_released, got.sda_released);
          cmp_field("busy_res", want.busy, got.busy);
          cmp_field("done_res", want.done, got.done);
          cmp_field("rx_byte", want.rx_byte, got.rx_byte);
          cmp_field("ack_timeout", want.ack_timeout, got.ack_timeout);
          cmp_field("rejected", want.rejected, got.rejected);
          n_checked++;
          if (want.done) n_done++;
          if (want.done && want.ack_timeout) n_tmo++;
          if (want.rejected) n_rej++;
        end
      end
      if (holdoff_len > 0) begin
        holdoff_left = holdoff_len;
        holdoff_len  = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(recv_gap_pct != 0 && $urandom_range(99) < recv_gap_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic send_item(input func_e fn, input logic [7:0] tx, input logic sack,
                           input logic sda, input logic typed, input result_t typed_line);
    result_t pred;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, sda, sack, tx};
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = sequencer_step(fn, tx, sack, sda);
    expected_lines.push_back(typed ? typed_line : pred);
    n_items++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_lines.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_SS_HOLD:   seq_cfg.ss_hold   = val;
      CFG_BIT_HALF:  seq_cfg.bit_half  = val;
      CFG_ACK_LIMIT: seq_cfg.ack_limit = val;
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [7:0] ss, input logic [7:0] half,
                            input logic [7:0] lim);
    write_reg(CFG_SS_HOLD, ss);
    write_reg(CFG_BIT_HALF, half);
    write_reg(CFG_ACK_LIMIT, lim);
  endtask

  // One command, then ticks until the sequencer is idle again. fn_sel < 0 picks a
  // random command; ack_after < 0 picks how many high polls precede the ACK.
  task automatic run_sequence(input int fn_sel, input int ack_after);
    func_e      fn;
    int         polls;
    logic [7:0] tx;
    logic       sack;
    logic       sda;
    if (fn_sel >= 0) fn = func_e'(fn_sel);
    else if ($urandom_range(99) < 85) fn = func_e'($urandom_range(1, 5));
    else fn = func_e'($urandom_range(0, 7));
    if (ack_after < 0)
      ack_after = $urandom_range(0, (seq_cfg.ack_limit > 20) ? 20 : seq_cfg.ack_limit + 2);
    tx   = 8'($urandom);
    sack = 1'($urandom);
    sda  = 1'($urandom);
    send_item(fn, tx, sack, sda, 1'b0, '0);
    polls = 0;
    while (seq_ph != PH_IDLE) begin
      tx   = 8'($urandom);
      sack = 1'($urandom);
      sda  = 1'($urandom);
      if (fn_sel < 0 && $urandom_range(99) < 4) begin
        // command while busy (rejected) or an unused code
        send_item(func_e'($urandom_range(1, 7)), tx, sack, sda, 1'b0, '0);
      end else begin
        if (seq_ph == PH_KP) begin
          sda = (polls < ack_after);
          polls++;
        end
        send_item(FN_TICK, tx, sack, sda, 1'b0, '0);
      end
    end
  endtask

  // Directed table. Result layout of typed lines: [0] scl, [1] sda, [2] released,
  // [3] busy, [4] done, [12:5] rx, [13] timeout, [14] rejected.
  localparam result_t LINE_IDLE     = 15'h0003;
  localparam result_t LINE_START    = 15'h000B;
  localparam result_t LINE_REJ      = 15'h400B;
  localparam result_t LINE_TMO_STOP = 15'h2008;

  typedef struct packed {
    logic       reg_wr;   // row writes a register (value in tx) instead of an item
    logic [1:0] reg_idx;
    func_e      fn;
    logic [7:0] tx;
    logic       sack;
    logic       sda;
    logic [3:0] reps;
    logic       typed;
    result_t    line;
  } dir_row_t;

  localparam int DIR_N = 16;
  dir_row_t dir_rows [DIR_N] = '{
    '{1'b0, CFG_SS_HOLD,   FN_TICK,     8'h00, 1'b0, 1'b0, 4'd1, 1'b1, LINE_IDLE},
    '{1'b0, CFG_SS_HOLD,   FN_RSVD6,    8'hFF, 1'b1, 1'b1, 4'd1, 1'b1, LINE_IDLE},
    '{1'b0, CFG_SS_HOLD,   FN_RSVD7,    8'h00, 1'b0, 1'b0, 4'd1, 1'b1, LINE_IDLE},
    '{1'b0, CFG_SS_HOLD,   FN_START,    8'h00, 1'b0, 1'b0, 4'd1, 1'b1, LINE_START},
    '{1'b0, CFG_SS_HOLD,   FN_READ,     8'hFF, 1'b1, 1'b1, 4'd1, 1'b1, LINE_REJ},
    '{1'b0, CFG_SS_HOLD,   FN_TICK,     8'h00, 1'b0, 1'b1, 4'd8, 1'b0, '0},
    // zero registers: holds count as one tick, first high poll times out
    '{1'b1, CFG_SS_HOLD,   FN_TICK,     8'h00, 1'b0, 1'b0, 4'd1, 1'b0, '0},
    '{1'b1, CFG_BIT_HALF,  FN_TICK,     8'h00, 1'b0, 1'b0, 4'd1, 1'b0, '0},
    '{1'b1, CFG_ACK_LIMIT, FN_TICK,     8'h00, 1'b0, 1'b0, 4'd1, 1'b0, '0},
    '{1'b0, CFG_SS_HOLD,   FN_WAIT_ACK, 8'h5A, 1'b0, 1'b0, 4'd1, 1'b0, '0},
    '{1'b0, CFG_SS_HOLD,   FN_TICK,     8'h00, 1'b0, 1'b1, 4'd2, 1'b0, '0},
    '{1'b0, CFG_SS_HOLD,   FN_TICK,     8'h00, 1'b0, 1'b1, 4'd1, 1'b1, LINE_TMO_STOP},
    '{1'b0, CFG_SS_HOLD,   FN_TICK,     8'hFF, 1'b1, 1'b0, 4'd2, 1'b0, '0},
    '{1'b0, CFG_SS_HOLD,   FN_STOP,     8'h00, 1'b1, 1'b1, 4'd1, 1'b0, '0},
    '{1'b0, CFG_SS_HOLD,   FN_TICK,     8'h00, 1'b0, 1'b0, 4'd2, 1'b0, '0},
    '{1'b0, CFG_SS_HOLD,   FN_WRITE,    8'h80, 1'b0, 1'b1, 4'd1, 1'b0, '0}
  };

  initial begin
    int start_items;
    seq_cfg     = '{ss_hold: SS_HOLD_RST, bit_half: BIT_HALF_RST, ack_limit: ACK_LIMIT_RST};
    seq_ph      = PH_IDLE;
    seq_hold    = '0;
    seq_shift   = '0;
    seq_polls   = '0;
    seq_rx      = '0;
    seq_bits    = '0;
    seq_ack_sel = 1'b0;
    seq_scl     = 1'b1;
    seq_sda     = 1'b1;
    seq_rel     = 1'b0;
    seq_tmo     = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].reg_wr) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].tx);
      end else begin
        repeat (dir_rows[i].reps)
          send_item(dir_rows[i].fn, dir_rows[i].tx, dir_rows[i].sack, dir_rows[i].sda,
                    dir_rows[i].typed, dir_rows[i].line);
      end
    end
    // a read command while the write still runs
    send_item(FN_READ, 8'h00, 1'b1, 1'b0, 1'b0, '0);

    // random part: receiver-heavy gaps, sender-heavy gaps, then none
    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 6 : (mode == 1) ? 55 : 0;
      recv_gap_pct = (mode == 0) ? 55 : (mode == 1) ? 6 : 0;
      for (int k = 0; k < 6; k++) begin
        case (k)
          0: write_regs(8'd0, 8'd0, 8'd0);
          1: write_regs(8'd1, 8'd1, 8'd1);
          2: write_regs(SS_HOLD_RST, BIT_HALF_RST, ACK_LIMIT_RST);
          3: write_regs(8'd2, 8'd3, 8'd5);
          4: write_regs(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                        8'($urandom_range(0, 12)));
          default: write_regs(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                              8'($urandom_range(0, 3)));
        endcase
        // long receiver hold-off while items keep coming
        if (mode == 0 && k == 0) holdoff_len = 200;
        start_items = n_items;
        while (n_items - start_items < 50) run_sequence(-1, -1);
      end
    end

    // register extremes, few long sequences
    write_regs(8'd255, 8'd1, 8'd255);
    run_sequence(FN_START, 0);
    write_regs(8'd1, 8'd1, 8'd255);
    run_sequence(FN_WAIT_ACK, 1000);

    wait_drained();
    repeat (5) @(posedge clk_i);

    $display("%0d input items, %0d result items checked", n_items, n_checked);
    $display("%0d sequences completed, %0d ack timeouts, %0d commands rejected",
             n_done, n_tmo, n_rej);
    if (n_errs == 0 && expected_lines.size() == 0) begin
      $display("i2c_master_bit_sequencer_unit regression: pass");
    end else begin
      $display("i2c_master_bit_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule
